// ===== src/sspwm_pkg.sv =====
// Shared constants and types for the four-channel shadowed PWM block.
package sspwm_pkg;

  localparam int NUM_CHAN = 4;
  localparam int FIELD_BITS = 15;
  localparam int COUNT_BITS_DEF = 15;

  typedef logic [NUM_CHAN-1:0] chan_vec_t;
  typedef logic [FIELD_BITS-1:0] field_t;

endpackage

// ===== src/sspwm_lane.sv =====
// One PWM channel: counter, shadow period, shadow position and output level.
module sspwm_lane #(
  parameter int COUNT_BITS = sspwm_pkg::COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic                   reset_req,
  input  sspwm_pkg::field_t      duty_pos,
  input  sspwm_pkg::field_t      period,
  output logic                   level_next
);
  import sspwm_pkg::*;

  localparam int WIDE_BITS = COUNT_BITS + FIELD_BITS;

  logic [COUNT_BITS-1:0] counter;
  logic [COUNT_BITS-1:0] shadow_period;
  logic [COUNT_BITS-1:0] shadow_pos;
  logic                  level;

  logic [COUNT_BITS-1:0] counter_next;
  logic [COUNT_BITS-1:0] shadow_period_next;
  logic [COUNT_BITS-1:0] shadow_pos_next;
  logic [COUNT_BITS-1:0] cnt_eff;
  logic [COUNT_BITS-1:0] per_eff;
  logic                  level_eff;
  logic [WIDE_BITS-1:0]  pos_wide;
  logic [WIDE_BITS-1:0]  per_wide;

  assign pos_wide = {{COUNT_BITS{1'b0}}, duty_pos};
  assign per_wide = {{COUNT_BITS{1'b0}}, period};

  always_comb begin
    cnt_eff = reset_req ? {COUNT_BITS{1'b1}} : counter;
    per_eff = reset_req ? '0 : shadow_period;
    level_eff = reset_req ? 1'b0 : level;
    shadow_pos_next = shadow_pos;
    shadow_period_next = per_eff;
    if (cnt_eff >= per_eff) begin
      counter_next = '0;
      shadow_pos_next = pos_wide[COUNT_BITS-1:0];
      shadow_period_next = per_wide[COUNT_BITS-1:0];
      level_next = 1'b1;
    end else begin
      level_next = (cnt_eff == shadow_pos) ? 1'b0 : level_eff;
      counter_next = cnt_eff + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
      shadow_period <= '0;
      shadow_pos <= '0;
      level <= 1'b0;
    end else if (step) begin
      counter <= counter_next;
      shadow_period <= shadow_period_next;
      shadow_pos <= shadow_pos_next;
      level <= level_next;
    end
  end

endmodule

// ===== src/sspwm_merge.sv =====
// Output register that gathers the lane levels into one result beat.
module sspwm_merge (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sspwm_pkg::chan_vec_t  lane_level,
  output logic                  step,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sspwm_pkg::chan_vec_t  levels
);
  import sspwm_pkg::*;

  assign in_ready = !out_valid || out_ready;
  assign step = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      levels <= lane_level;
    end
  end

endmodule

// ===== src/shadowed_slow_pwm_x4.sv =====
// Top level of the four-channel shadowed slow PWM block.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------
//   input   | in_valid / in_ready  | reset_req_0..3, duty_pos_0..3, period_0..3
//   output  | out_valid / out_ready| pwm_out_0..3
//
// One tick per cycle while in_ready is high: all four lanes compare and increment in parallel and
// the result beat appears in the output register the cycle after acceptance.
// The lane levels pass through the single output register.
// Reset clears every lane counter, shadow and level, and the output valid.
// While a result beat waits and out_ready is low, in_ready drops.
module shadowed_slow_pwm_x4 #(
  parameter int COUNT_BITS = sspwm_pkg::COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              reset_req_0,
  input  logic              reset_req_1,
  input  logic              reset_req_2,
  input  logic              reset_req_3,
  input  sspwm_pkg::field_t duty_pos_0,
  input  sspwm_pkg::field_t duty_pos_1,
  input  sspwm_pkg::field_t duty_pos_2,
  input  sspwm_pkg::field_t duty_pos_3,
  input  sspwm_pkg::field_t period_0,
  input  sspwm_pkg::field_t period_1,
  input  sspwm_pkg::field_t period_2,
  input  sspwm_pkg::field_t period_3,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              pwm_out_0,
  output logic              pwm_out_1,
  output logic              pwm_out_2,
  output logic              pwm_out_3
);
  import sspwm_pkg::*;

  logic      step;
  chan_vec_t req_vec;
  chan_vec_t lane_level;
  chan_vec_t levels;
  field_t    pos_arr [NUM_CHAN];
  field_t    per_arr [NUM_CHAN];

  assign req_vec = {reset_req_3, reset_req_2, reset_req_1, reset_req_0};
  assign pos_arr[0] = duty_pos_0;
  assign pos_arr[1] = duty_pos_1;
  assign pos_arr[2] = duty_pos_2;
  assign pos_arr[3] = duty_pos_3;
  assign per_arr[0] = period_0;
  assign per_arr[1] = period_1;
  assign per_arr[2] = period_2;
  assign per_arr[3] = period_3;

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
    sspwm_lane #(
      .COUNT_BITS(COUNT_BITS)
    ) u_lane (
      .clk        (clk),
      .rst        (rst),
      .step       (step),
      .reset_req  (req_vec[c]),
      .duty_pos   (pos_arr[c]),
      .period     (per_arr[c]),
      .level_next (lane_level[c])
    );
  end

  sspwm_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .lane_level (lane_level),
    .step       (step),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .levels     (levels)
  );

  assign pwm_out_0 = levels[0];
  assign pwm_out_1 = levels[1];
  assign pwm_out_2 = levels[2];
  assign pwm_out_3 = levels[3];

  a_beat_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted tick produced no result beat");

  a_reset_high_0: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && reset_req_0 |=> pwm_out_0)
    else $error("channel 0 reset did not restart the period high");

  a_reset_high_3: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && reset_req_3 |=> pwm_out_3)
    else $error("channel 3 reset did not restart the period high");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(levels))
    else $error("result beat changed while stalled");

endmodule

// ===== tb/sv/pwm_level_checker.sv =====
// Checker that mirrors the four PWM lanes and compares every result beat.
module pwm_level_checker #(
  parameter int COUNT_BITS = sspwm_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  sspwm_pkg::chan_vec_t            reset_req,
  input  logic [sspwm_pkg::NUM_CHAN-1:0][sspwm_pkg::FIELD_BITS-1:0] duty_pos,
  input  logic [sspwm_pkg::NUM_CHAN-1:0][sspwm_pkg::FIELD_BITS-1:0] period,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  sspwm_pkg::chan_vec_t            pwm_out,
  output int                              mismatches,
  output int                              pending
);
  import sspwm_pkg::*;

  typedef logic [COUNT_BITS-1:0] count_t;

  count_t    lane_count  [NUM_CHAN];
  count_t    lane_period [NUM_CHAN];
  count_t    lane_pos    [NUM_CHAN];
  chan_vec_t lane_level;
  chan_vec_t level_q [$];

  function automatic chan_vec_t advance_lanes(
    input chan_vec_t                           req,
    input logic [NUM_CHAN-1:0][FIELD_BITS-1:0] pos,
    input logic [NUM_CHAN-1:0][FIELD_BITS-1:0] per
  );
    for (int c = 0; c < NUM_CHAN; c++) begin
      if (req[c]) begin
        lane_count[c]  = '1;
        lane_period[c] = '0;
        lane_level[c]  = 1'b0;
      end
      if (lane_count[c] >= lane_period[c]) begin
        lane_count[c]  = '0;
        lane_pos[c]    = count_t'(pos[c]);
        lane_period[c] = count_t'(per[c]);
        lane_level[c]  = 1'b1;
      end else begin
        if (lane_count[c] == lane_pos[c]) begin
          lane_level[c] = 1'b0;
        end
        lane_count[c] = lane_count[c] + count_t'(1);
      end
    end
    return lane_level;
  endfunction

  always @(posedge clk) begin
    chan_vec_t want;
    if (rst) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        lane_count[c]  = '0;
        lane_period[c] = '0;
        lane_pos[c]    = '0;
      end
      lane_level = '0;
      level_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (level_q.size() == 0) begin
          if (mismatches < 50) begin
            $display("%0t: result beat with no tick pending, expected none, actual %b",
                     $time, pwm_out);
          end
          mismatches++;
        end else begin
          want = level_q.pop_front();
          for (int c = 0; c < NUM_CHAN; c++) begin
            if (pwm_out[c] !== want[c]) begin
              if (mismatches < 50) begin
                $display("%0t: pwm_out_%0d expected %b actual %b",
                         $time, c, want[c], pwm_out[c]);
              end
              mismatches++;
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        level_q.push_back(advance_lanes(reset_req, duty_pos, period));
      end
    end
    pending = level_q.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the four-channel shadowed PWM block: stimulus and verdict.
module tb;
  import sspwm_pkg::*;

  localparam int TICKS       = 2000;
  localparam int LIMIT       = 400000;
  localparam int HOLD_CYCLES = 64;
  localparam int DRAIN       = 4;

  typedef logic [NUM_CHAN-1:0][FIELD_BITS-1:0] lane_fields_t;

  typedef struct packed {
    chan_vec_t    req;
    lane_fields_t pos;
    lane_fields_t per;
  } tick_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_ready;
  logic   reset_req_0 = 1'b0;
  logic   reset_req_1 = 1'b0;
  logic   reset_req_2 = 1'b0;
  logic   reset_req_3 = 1'b0;
  field_t duty_pos_0 = '0;
  field_t duty_pos_1 = '0;
  field_t duty_pos_2 = '0;
  field_t duty_pos_3 = '0;
  field_t period_0 = '0;
  field_t period_1 = '0;
  field_t period_2 = '0;
  field_t period_3 = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  logic   pwm_out_0;
  logic   pwm_out_1;
  logic   pwm_out_2;
  logic   pwm_out_3;

  int mismatches;
  int pending;
  int cycles = 0;
  int ticks_sent = 0;
  int lane_resets = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  tick_t plan [$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  shadowed_slow_pwm_x4 dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .reset_req_0 (reset_req_0),
    .reset_req_1 (reset_req_1),
    .reset_req_2 (reset_req_2),
    .reset_req_3 (reset_req_3),
    .duty_pos_0  (duty_pos_0),
    .duty_pos_1  (duty_pos_1),
    .duty_pos_2  (duty_pos_2),
    .duty_pos_3  (duty_pos_3),
    .period_0    (period_0),
    .period_1    (period_1),
    .period_2    (period_2),
    .period_3    (period_3),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pwm_out_0   (pwm_out_0),
    .pwm_out_1   (pwm_out_1),
    .pwm_out_2   (pwm_out_2),
    .pwm_out_3   (pwm_out_3)
  );

  pwm_level_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .reset_req  ({reset_req_3, reset_req_2, reset_req_1, reset_req_0}),
    .duty_pos   ({duty_pos_3, duty_pos_2, duty_pos_1, duty_pos_0}),
    .period     ({period_3, period_2, period_1, period_0}),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pwm_out    ({pwm_out_3, pwm_out_2, pwm_out_1, pwm_out_0}),
    .mismatches (mismatches),
    .pending    (pending)
  );

  function automatic lane_fields_t lanes(input int a, input int b, input int c, input int d);
    return {field_t'(d), field_t'(c), field_t'(b), field_t'(a)};
  endfunction

  function automatic tick_t draw_tick();
    tick_t t;
    int    r;
    int    per;
    for (int c = 0; c < NUM_CHAN; c++) begin
      t.req[c] = ($urandom_range(0, 99) < 3);
      r = $urandom_range(0, 99);
      if (r < 85) begin
        per = $urandom_range(0, 12);
      end else if (r < 95) begin
        per = $urandom_range(0, 300);
      end else begin
        per = $urandom_range(0, 32767);
      end
      t.per[c] = field_t'(per);
      if ($urandom_range(0, 99) < 90) begin
        t.pos[c] = field_t'($urandom_range(0, per + 2));
      end else begin
        t.pos[c] = field_t'($urandom_range(0, 32767));
      end
    end
    return t;
  endfunction

  task automatic offer_tick(input tick_t t);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    reset_req_0 = t.req[0];
    reset_req_1 = t.req[1];
    reset_req_2 = t.req[2];
    reset_req_3 = t.req[3];
    duty_pos_0  = t.pos[0];
    duty_pos_1  = t.pos[1];
    duty_pos_2  = t.pos[2];
    duty_pos_3  = t.pos[3];
    period_0    = t.per[0];
    period_1    = t.per[1];
    period_2    = t.per[2];
    period_3    = t.per[3];
    in_valid    = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
    lane_resets += $countones(t.req);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int stall;
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = calm ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    plan.push_back('{4'b0000, lanes(0, 0, 0, 0), lanes(0, 0, 0, 0)});
    plan.push_back('{4'b1111, lanes(1, 3, 9, 32767), lanes(4, 2, 6, 32767)});
    repeat (8) plan.push_back('{4'b0000, lanes(2, 0, 32767, 5), lanes(3, 0, 32767, 7)});
    plan.push_back('{4'b0010, lanes(32767, 32767, 0, 0), lanes(32767, 32767, 0, 0)});
    plan.push_back('{4'b0101, lanes(0, 1, 2, 3), lanes(1, 2, 3, 4)});
    repeat (6) plan.push_back('{4'b0000, lanes(0, 1, 2, 3), lanes(1, 2, 3, 4)});
    plan.push_back('{4'b1000, lanes(5, 5, 5, 5), lanes(5, 5, 5, 5)});
    repeat (3) plan.push_back('{4'b0000, lanes(0, 0, 0, 0), lanes(0, 0, 0, 0)});

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) offer_tick(plan[i]);

    for (int n = 0; n < TICKS; n++) begin
      if (n % 150 == 0) begin
        calm = ($urandom_range(0, 2) == 0);
      end
      if (n == 600) begin
        calm = 1'b1;
        hold_req = 1'b1;
      end
      if (n == 1200) begin
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
      end
      offer_tick(draw_tick());
    end
    in_valid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Ran %0d ticks through four PWM lanes with %0d lane resets,", ticks_sent,
             lane_resets);
    $display("covering zero and maximum periods, a long output stall and a full drain.");
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== shadowed_slow_pwm_x4.f =====
src/sspwm_pkg.sv
src/sspwm_lane.sv
src/sspwm_merge.sv
src/shadowed_slow_pwm_x4.sv
tb/sv/pwm_level_checker.sv
tb/sv/tb.sv
